// ----- sv/pss_pkg.sv -----
// ---------------------------------------------------------------------------
// pss_pkg
// Types and constants shared by the power supply sequencer core.
// ---------------------------------------------------------------------------
package pss_pkg;

   localparam int unsigned DIV_W    = 10;
   localparam int unsigned LONG_W   = 8;
   localparam int unsigned DEB_W    = 10;
   localparam int unsigned CNT_W    = 16;
   localparam int unsigned CSR_IDX_W  = 3;
   localparam int unsigned CSR_DATA_W = 16;

   localparam logic [CNT_W-1:0] BLINK_TOP = 16'd15;
   localparam logic [CNT_W-1:0] CNT_MAX   = 16'hFFFF;

   // reset values of the control registers
   localparam logic [DIV_W-1:0]  TICKS_PER_TENTH_RST   = 10'd100;
   localparam logic [LONG_W-1:0] LONG_PRESS_TENTHS_RST = 8'd20;
   localparam logic [DEB_W-1:0]  DEBOUNCE_TICKS_RST    = 10'd35;
   localparam logic [CNT_W-1:0]  SETTLE_TICKS_RST      = 16'd500;
   localparam logic [CNT_W-1:0]  FAULT_BLINK_TICKS_RST = 16'd200;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TICKS_PER_TENTH   = 3'd0,
      CSR_LONG_PRESS_TENTHS = 3'd1,
      CSR_DEBOUNCE_TICKS    = 3'd2,
      CSR_SETTLE_TICKS      = 3'd3,
      CSR_FAULT_BLINK_TICKS = 3'd4
   } csr_index_type;

   typedef enum logic [2:0] {
      MODE_STANDBY  = 3'd0,
      MODE_DEBOUNCE = 3'd1,
      MODE_SETTLE   = 3'd2,
      MODE_ON       = 3'd3,
      MODE_WAIT     = 3'd4,
      MODE_FAULT    = 3'd5
   } mode_type;

   typedef struct packed {
      logic button_pressed;
      logic external_request;
      logic power_good;
   } req_type;

   typedef struct packed {
      logic       supply_enable;
      logic       power_lamp;
      logic       error_led;
      logic [2:0] mode;
   } rsp_type;

endpackage

// ----- sv/power_supply_sequencer_core.sv -----
// ---------------------------------------------------------------------------
// power_supply_sequencer_core
// Tick-driven power sequencer: standby blink, debounce, settle, on,
// long-press switch-off and latched power-good fault.
// ---------------------------------------------------------------------------
// The result of an accepted tick transaction is registered and appears in the next cycle.
// Throughput: one tick per cycle unless a waiting result is stalled; all state updates in a single pass.
// The result register frees the input side whenever it is empty or being
// drained, so req_stall only follows rsp_stall.
// Reset (synchronous): standby, counters cleared, registers at defaults.
module power_supply_sequencer_core (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  pss_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output pss_pkg::rsp_type                    rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [pss_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [pss_pkg::CSR_DATA_W-1:0]      csr_data
);
   import pss_pkg::*;

   // control registers
   logic [DIV_W-1:0]  tpt_ff;
   logic [LONG_W-1:0] lpt_ff;
   logic [DEB_W-1:0]  deb_ff;
   logic [CNT_W-1:0]  settle_ff;
   logic [CNT_W-1:0]  blink_ff;

   // sequencer state
   mode_type          mode_ff, mode_in;
   logic [CNT_W-1:0]  delay_ff, delay_in;
   logic [DIV_W-1:0]  presc_ff, presc_in;
   logic [CNT_W-1:0]  tenth_ff, tenth_in;
   logic              armed_ff, armed_in;
   logic              enable_ff, enable_in;
   logic              led_ff, led_in;
   logic              error_ff, error_in;

   logic              rsp_valid_ff, rsp_valid_in;
   rsp_type           rsp_data_ff, rsp_data_in;

   logic              accept;
   logic              csr_we;
   logic [DIV_W-1:0]  div;
   logic [CNT_W-1:0]  blink_lim;
   logic [DIV_W-1:0]  presc_inc;
   logic [CNT_W-1:0]  tenth_adv;
   logic [CNT_W-1:0]  tenth_on;
   logic [CNT_W-1:0]  delay_inc;
   logic [CNT_W-1:0]  lpt_ext;
   logic              deb_done, settle_done, blink_done;
   logic              btn, ext, pg;
   logic              arm_now;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid & csr_ready;

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   assign btn = req_data.button_pressed;
   assign ext = req_data.external_request;
   assign pg  = req_data.power_good;

   // prescaler and tenth counter advance before the mode logic
   assign div       = (tpt_ff == '0) ? DIV_W'(1) : tpt_ff;
   assign blink_lim = (blink_ff == '0) ? CNT_W'(1) : blink_ff;
   assign presc_inc = presc_ff + DIV_W'(1);
   assign tenth_adv = (presc_inc >= div) ? tenth_ff + CNT_W'(1) : tenth_ff;

   // saturating delay counter shared by debounce, settle and fault
   assign delay_inc   = (delay_ff == CNT_MAX) ? delay_ff : delay_ff + CNT_W'(1);
   assign deb_done    = delay_inc >= {{(CNT_W-DEB_W){1'b0}}, deb_ff};
   assign settle_done = delay_inc >= settle_ff;
   assign blink_done  = delay_inc >= blink_lim;

   assign lpt_ext  = {{(CNT_W-LONG_W){1'b0}}, lpt_ff};
   assign arm_now  = btn & ~armed_ff;
   assign tenth_on = arm_now ? '0 : tenth_adv;

   // next mode
   always_comb begin
      case (mode_ff)
         MODE_DEBOUNCE: begin
            if (!deb_done) mode_in = MODE_DEBOUNCE;
            else if (btn || ext) mode_in = MODE_SETTLE;
            else mode_in = MODE_STANDBY;
         end
         MODE_SETTLE: mode_in = settle_done ? MODE_ON : MODE_SETTLE;
         MODE_ON: begin
            if (!pg) mode_in = MODE_FAULT;
            else if (btn && tenth_on > lpt_ext) mode_in = MODE_WAIT;
            else mode_in = MODE_ON;
         end
         MODE_WAIT:  mode_in = btn ? MODE_WAIT : MODE_STANDBY;
         MODE_FAULT: mode_in = MODE_FAULT;
         default:    mode_in = (btn || ext) ? MODE_DEBOUNCE : MODE_STANDBY;
      endcase
   end

   // counters, latches and pin levels
   always_comb begin
      presc_in  = (presc_inc >= div) ? '0 : presc_inc;
      tenth_in  = tenth_adv;
      delay_in  = delay_ff;
      armed_in  = armed_ff;
      enable_in = enable_ff;
      led_in    = led_ff;
      error_in  = error_ff;
      case (mode_ff)
         MODE_DEBOUNCE: begin
            delay_in = delay_inc;
            if (deb_done && (btn || ext)) begin
               enable_in = 1'b1;
               led_in    = 1'b1;
               delay_in  = '0;
            end
         end
         MODE_SETTLE: delay_in = delay_inc;
         MODE_ON: begin
            if (!pg) begin
               enable_in = 1'b0;
               led_in    = 1'b0;
               error_in  = 1'b1;
               delay_in  = '0;
            end else begin
               tenth_in = tenth_on;
               armed_in = armed_ff | btn;
               if (btn && tenth_on > lpt_ext) begin
                  enable_in = 1'b0;
                  led_in    = 1'b0;
                  error_in  = 1'b0;
               end else if (!btn && tenth_on <= lpt_ext) begin
                  armed_in = 1'b0;
               end
            end
         end
         MODE_WAIT: ;
         MODE_FAULT: begin
            enable_in = 1'b0;
            led_in    = 1'b0;
            if (blink_done) begin
               delay_in = '0;
               error_in = ~error_ff;
            end else begin
               delay_in = delay_inc;
            end
         end
         default: begin
            error_in = 1'b0;
            if (!btn && !ext) begin
               if (tenth_adv == '0) led_in = 1'b1;
               if (tenth_adv > CNT_W'(1) && tenth_adv <= BLINK_TOP) led_in = 1'b0;
               if (tenth_adv > BLINK_TOP) tenth_in = '0;
            end else begin
               delay_in = '0;
            end
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);
      rsp_data_in  = rsp_data_ff;
      if (accept) begin
         rsp_data_in.supply_enable = enable_in;
         rsp_data_in.power_lamp    = led_in;
         rsp_data_in.error_led     = error_in;
         rsp_data_in.mode          = mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tpt_ff    <= TICKS_PER_TENTH_RST;
         lpt_ff    <= LONG_PRESS_TENTHS_RST;
         deb_ff    <= DEBOUNCE_TICKS_RST;
         settle_ff <= SETTLE_TICKS_RST;
         blink_ff  <= FAULT_BLINK_TICKS_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_TICKS_PER_TENTH:   tpt_ff    <= csr_data[DIV_W-1:0];
            CSR_LONG_PRESS_TENTHS: lpt_ff    <= csr_data[LONG_W-1:0];
            CSR_DEBOUNCE_TICKS:    deb_ff    <= csr_data[DEB_W-1:0];
            CSR_SETTLE_TICKS:      settle_ff <= csr_data[CNT_W-1:0];
            CSR_FAULT_BLINK_TICKS: blink_ff  <= csr_data[CNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_STANDBY;
         delay_ff     <= '0;
         presc_ff     <= '0;
         tenth_ff     <= '0;
         armed_ff     <= 1'b0;
         enable_ff    <= 1'b0;
         led_ff       <= 1'b0;
         error_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            mode_ff   <= mode_in;
            delay_ff  <= delay_in;
            presc_ff  <= presc_in;
            tenth_ff  <= tenth_in;
            armed_ff  <= armed_in;
            enable_ff <= enable_in;
            led_ff    <= led_in;
            error_ff  <= error_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // supply drive follows the mode exactly
   a_enable_mode: assert property (@(posedge clock) disable iff (reset)
      enable_ff == (mode_ff == MODE_SETTLE || mode_ff == MODE_ON))
      else $error("supply enable out of step with mode");

   // error LED is only ever lit while faulted
   a_error_fault: assert property (@(posedge clock) disable iff (reset)
      error_ff |-> mode_ff == MODE_FAULT)
      else $error("error LED lit outside fault");

   // a faulted sequencer never leaves fault
   a_fault_sticky: assert property (@(posedge clock) disable iff (reset)
      mode_ff == MODE_FAULT |=> mode_ff == MODE_FAULT)
      else $error("fault state released without reset");

   // input is held off only when a result is waiting
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid_ff)
      else $error("input stalled with empty result register");

   // every accepted tick leaves a result behind
   a_accept_result: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_valid_ff && rsp_data_ff.mode == mode_ff)
      else $error("accepted tick produced no matching result");

endmodule
